// ===== sv/led_matrix_frame_store_scanner_macros.svh =====
// assertion macros for the led matrix frame store scanner checker
`ifndef LED_MATRIX_FRAME_STORE_SCANNER_MACROS_SVH
`define LED_MATRIX_FRAME_STORE_SCANNER_MACROS_SVH

// checked at every edge, reset included
`define LMFS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

// checked outside reset
`define LMFS_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

// ===== sv/lmfs_pkg.sv =====
// shared constants and tables of the led matrix frame store scanner
`timescale 1ns / 1ps

package lmfs_pkg;

  localparam int MAX_PANELS  = 4;
  localparam int STORE_DEPTH = 256;
  localparam int ADDR_W      = 8;
  localparam int BYTE_W      = 8;
  localparam int CFG_W       = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int KIND_W      = 2;
  localparam int X_W         = 7;
  localparam int Y_W         = 6;
  localparam int MODE_W      = 3;
  localparam int PHASE_W     = 2;
  localparam int BEAT_W      = 6;

  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SCAN  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  localparam logic [MODE_W-1:0] MODE_NORMAL  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_INVERSE = 3'd1;
  localparam logic [MODE_W-1:0] MODE_TOGGLE  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_OR      = 3'd3;
  localparam logic [MODE_W-1:0] MODE_NOR     = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_ACROSS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DOWN   = 2'd1;

  // scan order within one panel: byte column and row quarter
  localparam logic [1:0] SCAN_COL [16] = '{
    2'd0, 2'd0, 2'd1, 2'd1, 2'd0, 2'd0, 2'd1, 2'd1,
    2'd2, 2'd2, 2'd3, 2'd3, 2'd2, 2'd2, 2'd3, 2'd3
  };
  localparam logic [1:0] SCAN_ROW [16] = '{
    2'd3, 2'd2, 2'd3, 2'd2, 2'd1, 2'd0, 2'd1, 2'd0,
    2'd3, 2'd2, 2'd3, 2'd2, 2'd1, 2'd0, 2'd1, 2'd0
  };

endpackage

// ===== sv/lmfs_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps

module lmfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/led_matrix_frame_store_scanner.sv =====
// top level: frame store with pixel writes, quarter scans and clear
//
//   port group   handshake             beat contents
//   ----------   -------------------   ----------------------------------------------
//   in           in_valid / in_stall   kind pixel_x pixel_y draw_mode pixel_value scan_phase
//   out          out_valid / out_stall shift_byte row_select last
//   cfg          cfg_valid / cfg_ready cfg_index cfg_data
//
// pixel write: one read and, for a pixel on the display, one write of the 256 x 8 store ram
// scan: 16 * panels beats, one per cycle (ram read port) while the out beat is not stalled
// clear: after the accepting cycle, one ram entry per cycle through the write port
// reset starts the same clear; in_stall is high until it ends
// a stalled out beat holds the ram read, the scan resumes when it is taken
`timescale 1ns / 1ps

module led_matrix_frame_store_scanner (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [lmfs_pkg::KIND_W-1:0]   kind,
  input  logic [lmfs_pkg::X_W-1:0]      pixel_x,
  input  logic [lmfs_pkg::Y_W-1:0]      pixel_y,
  input  logic [lmfs_pkg::MODE_W-1:0]   draw_mode,
  input  logic                          pixel_value,
  input  logic [lmfs_pkg::PHASE_W-1:0]  scan_phase,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lmfs_pkg::BYTE_W-1:0]   shift_byte,
  output logic [lmfs_pkg::PHASE_W-1:0]  row_select,
  output logic                          last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lmfs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lmfs_pkg::CFG_W-1:0]    cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_WRITE,
    S_SCAN,
    S_DRAIN,
    S_CLEAR
  } state_t;

  state_t state;

  logic [lmfs_pkg::CFG_W-1:0]   across;
  logic [lmfs_pkg::CFG_W-1:0]   down;
  logic [lmfs_pkg::CFG_W-1:0]   total;
  logic [5:0]                   across_prod;
  logic [5:0]                   down_prod;

  logic [lmfs_pkg::ADDR_W-1:0]  clr_cnt;

  logic [lmfs_pkg::ADDR_W-1:0]  wr_addr;
  logic [lmfs_pkg::BYTE_W-1:0]  wr_mask;
  logic [lmfs_pkg::MODE_W-1:0]  wr_mode;
  logic                         wr_value;
  logic                         wr_hit;

  logic [lmfs_pkg::BEAT_W-1:0]  scan_cnt;
  logic [lmfs_pkg::BEAT_W-1:0]  scan_end;
  logic [lmfs_pkg::PHASE_W-1:0] phase;
  logic [lmfs_pkg::ADDR_W-1:0]  scan_off;
  logic [lmfs_pkg::ADDR_W-1:0]  row1;
  logic [lmfs_pkg::ADDR_W-1:0]  row2;
  logic [lmfs_pkg::ADDR_W-1:0]  row3;
  logic                         rd_pend;
  logic                         rd_last;

  logic                         in_accept;
  logic                         hit_x;
  logic                         hit_y;
  logic [lmfs_pkg::Y_W-1:0]     row_map;
  logic [4:0]                   panel_prod;
  logic [1:0]                   panel_idx;
  logic [8:0]                   row_off;
  logic [lmfs_pkg::ADDR_W-1:0]  pix_addr;
  logic [lmfs_pkg::BYTE_W-1:0]  pix_mask;

  logic [6:0]                   off_prod;
  logic [lmfs_pkg::CFG_W-1:0]   total_m1;
  logic [3:0]                   scan_k;
  logic [lmfs_pkg::ADDR_W-1:0]  row_base;
  logic [lmfs_pkg::ADDR_W-1:0]  scan_addr;
  logic                         out_load;
  logic                         scan_issue;

  logic                         ram_we;
  logic [lmfs_pkg::ADDR_W-1:0]  ram_waddr;
  logic [lmfs_pkg::BYTE_W-1:0]  ram_wdata;
  logic                         ram_re;
  logic [lmfs_pkg::ADDR_W-1:0]  ram_raddr;
  logic [lmfs_pkg::BYTE_W-1:0]  ram_rdata;
  logic [lmfs_pkg::BYTE_W-1:0]  new_byte;

  assign cfg_ready   = 1'b1;
  assign across_prod = {3'd0, cfg_data} * {3'd0, down};
  assign down_prod   = {3'd0, across} * {3'd0, cfg_data};

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && (state == S_IDLE);

  // pixel address path
  assign hit_x      = {1'b0, pixel_x} < {across, 5'd0};
  assign hit_y      = {1'b0, pixel_y} < {down, 4'd0};
  assign row_map    = (pixel_y[5:4] == 2'd0) ? {pixel_y[5:2], pixel_y[1:0] - 2'd1} : pixel_y;
  assign panel_prod = {2'd0, across} * {3'd0, row_map[5:4]};
  assign panel_idx  = panel_prod[1:0] + pixel_x[6:5];
  assign row_off    = {5'd0, row_map[3:0]} * {4'd0, total, 2'b00};
  assign pix_addr   = row_off[7:0] + {4'd0, panel_idx, pixel_x[4:3]};
  assign pix_mask   = 8'h80 >> pixel_x[2:0];

  // scan address path
  assign off_prod = {2'd0, total, 2'b00} * {5'd0, scan_phase};
  assign total_m1 = total - 3'd1;
  assign scan_k   = scan_cnt[3:0];

  always_comb begin
    case (lmfs_pkg::SCAN_ROW[scan_k])
      2'd0:    row_base = '0;
      2'd1:    row_base = row1;
      2'd2:    row_base = row2;
      default: row_base = row3;
    endcase
  end

  assign scan_addr = scan_off + {4'd0, scan_cnt[5:4], 2'b00}
                   + {6'd0, lmfs_pkg::SCAN_COL[scan_k]} + row_base;

  assign out_load   = rd_pend && (!out_valid || !out_stall);
  assign scan_issue = (state == S_SCAN) && (!rd_pend || out_load);

  // read-modify-write of one bit
  always_comb begin
    case (wr_mode)
      lmfs_pkg::MODE_NORMAL:
        new_byte = wr_value ? (ram_rdata | wr_mask) : (ram_rdata & ~wr_mask);
      lmfs_pkg::MODE_INVERSE:
        new_byte = wr_value ? (ram_rdata & ~wr_mask) : (ram_rdata | wr_mask);
      lmfs_pkg::MODE_TOGGLE:
        new_byte = wr_value ? (ram_rdata ^ wr_mask) : ram_rdata;
      lmfs_pkg::MODE_OR:
        new_byte = wr_value ? (ram_rdata | wr_mask) : ram_rdata;
      lmfs_pkg::MODE_NOR:
        new_byte = wr_value ? (ram_rdata & ~wr_mask) : ram_rdata;
      default:
        new_byte = ram_rdata;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wr_addr;
    ram_wdata = new_byte;
    case (state)
      S_WRITE: begin
        ram_we = wr_hit;
      end
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt;
        ram_wdata = '0;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  assign ram_re    = (in_accept && (kind == lmfs_pkg::KIND_WRITE)) || scan_issue;
  assign ram_raddr = (state == S_IDLE) ? pix_addr : scan_addr;

  lmfs_ram #(
    .WIDTH(lmfs_pkg::BYTE_W),
    .DEPTH(lmfs_pkg::STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
      across    <= 3'd1;
      down      <= 3'd1;
      total     <= 3'd1;
    end else begin
      // geometry registers, rejected when zero or too many panels
      if (cfg_valid && cfg_ready && (cfg_data != '0)) begin
        case (cfg_index)
          lmfs_pkg::CFG_ACROSS: begin
            if (across_prod <= 6'(lmfs_pkg::MAX_PANELS)) begin
              across <= cfg_data;
              total  <= across_prod[2:0];
            end
          end
          lmfs_pkg::CFG_DOWN: begin
            if (down_prod <= 6'(lmfs_pkg::MAX_PANELS)) begin
              down  <= cfg_data;
              total <= down_prod[2:0];
            end
          end
          default: begin
          end
        endcase
      end

      // output register
      if (out_load) begin
        out_valid  <= 1'b1;
        shift_byte <= ram_rdata;
        row_select <= phase;
        last       <= rd_last;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      // read in flight toward the output register
      if (scan_issue) begin
        rd_pend <= 1'b1;
        rd_last <= (scan_cnt == scan_end);
      end else if (out_load) begin
        rd_pend <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            case (kind)
              lmfs_pkg::KIND_WRITE: begin
                wr_addr  <= pix_addr;
                wr_mask  <= pix_mask;
                wr_mode  <= draw_mode;
                wr_value <= pixel_value;
                wr_hit   <= hit_x && hit_y;
                state    <= S_WRITE;
              end
              lmfs_pkg::KIND_SCAN: begin
                phase    <= scan_phase;
                scan_cnt <= '0;
                scan_end <= {total_m1[1:0], 4'hF};
                scan_off <= {1'b0, off_prod};
                row1     <= {1'b0, total, 4'd0};
                row2     <= {total, 5'd0};
                row3     <= {1'b0, total, 4'd0} + {total, 5'd0};
                state    <= S_SCAN;
              end
              lmfs_pkg::KIND_CLEAR: begin
                clr_cnt <= '0;
                state   <= S_CLEAR;
              end
              default: begin
              end
            endcase
          end
        end
        S_WRITE: begin
          state <= S_IDLE;
        end
        S_SCAN: begin
          if (scan_issue) begin
            scan_cnt <= scan_cnt + 6'd1;
            if (scan_cnt == scan_end) begin
              state <= S_DRAIN;
            end
          end
        end
        S_DRAIN: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 8'd1;
          if (clr_cnt == 8'hFF) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sv/lmfs_checker.sv =====
// port-level checker for the led matrix frame store scanner, bound to the top level
`timescale 1ns / 1ps
`include "led_matrix_frame_store_scanner_macros.svh"

module lmfs_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic [lmfs_pkg::KIND_W-1:0]  kind,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [lmfs_pkg::BYTE_W-1:0]  shift_byte,
  input logic [lmfs_pkg::PHASE_W-1:0] row_select,
  input logic                         last
);

  // the store clear after reset blocks the input side
  `LMFS_ASSERT(a_reset_clears, rst |=> in_stall, "input taken during reset clear")

  // a stalled beat holds its shift byte and last flag
  `LMFS_ASSERT_RST(a_out_hold, out_valid && out_stall |=> out_valid && $stable(shift_byte) && $stable(last), "stalled out beat changed")

  // a write, clear or unused kind never makes an out beat
  `LMFS_ASSERT_RST(a_no_spurious, in_valid && !in_stall && (kind != lmfs_pkg::KIND_SCAN) && !out_valid |=> !out_valid, "out beat without a scan")

  // row select stays put within one scan
  `LMFS_ASSERT_RST(a_row_steady, out_valid && !out_stall && !last |=> $stable(row_select), "row select changed inside a scan")

endmodule

bind led_matrix_frame_store_scanner lmfs_checker u_lmfs_checker (.*);

// ===== tb/sv/tb_led_matrix_frame_store_scanner.sv =====
// self-checking testbench for the led matrix frame store scanner
`timescale 1ns / 1ps

module tb_led_matrix_frame_store_scanner;
  import lmfs_pkg::*;

  localparam logic [KIND_W-1:0]    KIND_SPARE   = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;
  localparam int SETTLE_CYCLES = 300;
  localparam int DRAIN_LIMIT   = 50000;
  localparam int HOLD_CYCLES   = 400;

  typedef struct packed {
    logic [BYTE_W-1:0]  shift_byte;
    logic [PHASE_W-1:0] row_select;
    logic               last;
  } scan_beat_t;

  class scan_beat_scoreboard;
    logic [BYTE_W-1:0] store [STORE_DEPTH];
    int unsigned across;
    int unsigned down;
    scan_beat_t beats_due [$];
    int errors;
    int beats_checked;

    function new();
      across = 1;
      down = 1;
      errors = 0;
      beats_checked = 0;
      clear_store();
    endfunction

    function void clear_store();
      foreach (store[i]) store[i] = '0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      if (val == 0) return;
      if (idx == CFG_ACROSS) begin
        if (val * down <= MAX_PANELS) across = 32'(val);
      end else if (idx == CFG_DOWN) begin
        if (across * val <= MAX_PANELS) down = 32'(val);
      end
    endfunction

    function void note_item(logic [KIND_W-1:0] k, logic [X_W-1:0] x, logic [Y_W-1:0] y,
                            logic [MODE_W-1:0] m, logic v, logic [PHASE_W-1:0] ph);
      int unsigned total, py, panel, bx, addr, base;
      logic [1:0] row_in_group;
      logic [BYTE_W-1:0] mask, cur;
      scan_beat_t beat;
      total = across * down;
      case (k)
        KIND_WRITE: begin
          if (x < 32 * across && y < 16 * down) begin
            // rows of the first panel row are rotated within groups of four
            row_in_group = y[1:0] - 2'd1;
            py = (y < 16) ? 32'({y[5:2], row_in_group}) : 32'(y);
            panel = x / 32 + across * (py / 16);
            bx = x % 32 + panel * 32;
            addr = bx / 8 + (py % 16) * total * 4;
            if (addr < total * 64 && addr < STORE_DEPTH) begin
              mask = 8'h80 >> (bx % 8);
              cur = store[addr];
              case (m)
                MODE_NORMAL:  cur = v ? (cur | mask) : (cur & ~mask);
                MODE_INVERSE: cur = v ? (cur & ~mask) : (cur | mask);
                MODE_TOGGLE:  if (v) cur = cur ^ mask;
                MODE_OR:      if (v) cur = cur | mask;
                MODE_NOR:     if (v) cur = cur & ~mask;
                default: ;
              endcase
              store[addr] = cur;
            end
          end
        end
        KIND_SCAN: begin
          base = total * 4 * ph;
          for (int p = 0; p < total; p++) begin
            for (int i = 0; i < 16; i++) begin
              addr = base + SCAN_COL[i] + SCAN_ROW[i] * 16 * total;
              beat.shift_byte = store[addr % STORE_DEPTH];
              beat.row_select = ph;
              beat.last = (p == total - 1) && (i == 15);
              beats_due.push_back(beat);
            end
            base += 4;
          end
        end
        KIND_CLEAR: clear_store();
        default: ;
      endcase
    endfunction

    function void check_beat(logic [BYTE_W-1:0] b, logic [PHASE_W-1:0] r, logic l);
      scan_beat_t want;
      if (beats_due.size() == 0) begin
        $error("unexpected beat: shift_byte %02h row_select %0d last %0b", b, r, l);
        errors++;
        return;
      end
      want = beats_due.pop_front();
      beats_checked++;
      if (b !== want.shift_byte) begin
        $error("shift_byte expected %02h actual %02h", want.shift_byte, b);
        errors++;
      end
      if (r !== want.row_select) begin
        $error("row_select expected %0d actual %0d", want.row_select, r);
        errors++;
      end
      if (l !== want.last) begin
        $error("last expected %0b actual %0b", want.last, l);
        errors++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  logic [KIND_W-1:0]    kind;
  logic [X_W-1:0]       pixel_x;
  logic [Y_W-1:0]       pixel_y;
  logic [MODE_W-1:0]    draw_mode;
  logic                 pixel_value;
  logic [PHASE_W-1:0]   scan_phase;
  logic                 out_valid;
  logic                 out_stall;
  logic [BYTE_W-1:0]    shift_byte;
  logic [PHASE_W-1:0]   row_select;
  logic                 last;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  scan_beat_scoreboard sb;
  bit idling;
  int hold_cycles;
  int n_items, n_writes, n_scans, n_clears, n_geometries;

  led_matrix_frame_store_scanner dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .pixel_x(pixel_x), .pixel_y(pixel_y), .draw_mode(draw_mode),
    .pixel_value(pixel_value), .scan_phase(scan_phase),
    .out_valid(out_valid), .out_stall(out_stall),
    .shift_byte(shift_byte), .row_select(row_select), .last(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin : watchdog
    #4_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // output side: random stall bursts and one long hold-off on request
  initial begin : receiver
    int n;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_stall = 1'b1;
        n = hold_cycles;
        hold_cycles = 0;
        repeat (n - 1) @(negedge clk);
      end else if (idling && $urandom_range(0, 5) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(0, 5)) @(negedge clk);
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_beat(shift_byte, row_select, last);
  end

  task automatic send_item(logic [KIND_W-1:0] k, logic [X_W-1:0] x, logic [Y_W-1:0] y,
                           logic [MODE_W-1:0] m, logic v, logic [PHASE_W-1:0] ph);
    if (idling && $urandom_range(0, 3) == 0) begin
      @(negedge clk) in_valid = 1'b0;
      repeat ($urandom_range(0, 5)) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    kind = k;
    pixel_x = x;
    pixel_y = y;
    draw_mode = m;
    pixel_value = v;
    scan_phase = ph;
    do @(posedge clk); while (in_stall);
    sb.note_item(k, x, y, m, v, ph);
    n_items++;
    case (k)
      KIND_WRITE: n_writes++;
      KIND_SCAN:  n_scans++;
      KIND_CLEAR: n_clears++;
      default: ;
    endcase
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_register(idx, val);
    @(negedge clk) cfg_valid = 1'b0;
  endtask

  // across twice so that any legal target is reached from any legal start
  task automatic set_geometry(logic [CFG_W-1:0] a, logic [CFG_W-1:0] d);
    cfg_write(CFG_ACROSS, a);
    cfg_write(CFG_DOWN, d);
    cfg_write(CFG_ACROSS, a);
    n_geometries++;
  endtask

  task automatic drain();
    int waited;
    waited = 0;
    @(negedge clk) in_valid = 1'b0;
    while (sb.beats_due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    // writes and clears leave no beat behind, give them time to finish
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_items(int n);
    int r;
    logic [X_W-1:0] x;
    logic [Y_W-1:0] y;
    logic [MODE_W-1:0] m;
    logic v;
    logic [PHASE_W-1:0] ph;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      x = X_W'($urandom);
      y = Y_W'($urandom);
      m = MODE_W'($urandom);
      v = 1'($urandom);
      ph = PHASE_W'($urandom);
      if (r < 60) begin
        x = X_W'($urandom_range(32 * sb.across - 1, 0));
        y = Y_W'($urandom_range(16 * sb.down - 1, 0));
        if (r < 55) m = MODE_W'($urandom_range(MODE_NOR, MODE_NORMAL));
        send_item(KIND_WRITE, x, y, m, v, ph);
      end else if (r < 68) begin
        send_item(KIND_WRITE, x, y, m, v, ph);
      end else if (r < 92) begin
        send_item(KIND_SCAN, x, y, m, v, ph);
      end else if (r < 96) begin
        send_item(KIND_CLEAR, x, y, m, v, ph);
      end else begin
        send_item(KIND_SPARE, x, y, m, v, ph);
      end
    end
  endtask

  initial begin : stimulus
    sb = new();
    idling = 1'b1;
    hold_cycles = 0;
    n_items = 0;
    n_writes = 0;
    n_scans = 0;
    n_clears = 0;
    n_geometries = 1;
    rst = 1'b1;
    in_valid = 1'b0;
    kind = KIND_WRITE;
    pixel_x = '0;
    pixel_y = '0;
    draw_mode = MODE_NORMAL;
    pixel_value = 1'b0;
    scan_phase = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_ACROSS;
    cfg_data = '0;
    repeat (5) @(posedge clk);
    @(negedge clk) rst = 1'b0;

    // directed: corners, every mode, undefined modes, off-display pixels
    send_item(KIND_WRITE, 7'd0, 6'd0, MODE_NORMAL, 1'b1, 2'd0);
    send_item(KIND_WRITE, 7'd31, 6'd15, MODE_NORMAL, 1'b1, 2'd0);
    send_item(KIND_WRITE, 7'd5, 6'd1, MODE_INVERSE, 1'b0, 2'd0);
    send_item(KIND_WRITE, 7'd6, 6'd1, MODE_INVERSE, 1'b1, 2'd0);
    send_item(KIND_WRITE, 7'd7, 6'd2, MODE_TOGGLE, 1'b1, 2'd0);
    send_item(KIND_WRITE, 7'd7, 6'd2, MODE_TOGGLE, 1'b0, 2'd0);
    send_item(KIND_WRITE, 7'd8, 6'd3, MODE_OR, 1'b1, 2'd0);
    send_item(KIND_WRITE, 7'd9, 6'd3, MODE_OR, 1'b0, 2'd0);
    send_item(KIND_WRITE, 7'd8, 6'd3, MODE_NOR, 1'b0, 2'd0);
    send_item(KIND_WRITE, 7'd31, 6'd15, MODE_NOR, 1'b1, 2'd0);
    for (int md = MODE_NOR + 1; md < (1 << MODE_W); md++)
      send_item(KIND_WRITE, 7'd10, 6'd4, MODE_W'(md), 1'b1, 2'd0);
    send_item(KIND_WRITE, 7'd127, 6'd63, MODE_NORMAL, 1'b1, 2'd3);
    send_item(KIND_WRITE, 7'd32, 6'd0, MODE_NORMAL, 1'b1, 2'd0);
    send_item(KIND_WRITE, 7'd0, 6'd16, MODE_NORMAL, 1'b1, 2'd0);
    send_item(KIND_SPARE, 7'd127, 6'd63, 3'd7, 1'b1, 2'd3);
    for (int p = 0; p < 4; p++)
      send_item(KIND_SCAN, 7'd0, 6'd0, MODE_NORMAL, 1'b0, PHASE_W'(p));
    send_item(KIND_CLEAR, 7'd0, 6'd0, MODE_NORMAL, 1'b0, 2'd0);
    send_item(KIND_SCAN, 7'd0, 6'd0, MODE_NORMAL, 1'b0, 2'd0);
    drain();

    set_geometry(3'd4, 3'd1);
    random_items(40);
    drain();
    set_geometry(3'd1, 3'd4);
    random_items(40);
    drain();

    // rejected and ignored register writes
    cfg_write(CFG_ACROSS, 3'd0);
    cfg_write(CFG_DOWN, 3'd7);
    cfg_write(CFG_ACROSS, 3'd2);
    cfg_write(CFG_SPARE_LO, 3'd7);
    cfg_write(CFG_SPARE_HI, 3'd1);
    random_items(30);
    drain();

    // long output hold-off while scans keep coming
    set_geometry(3'd2, 3'd2);
    hold_cycles = HOLD_CYCLES;
    repeat (12) send_item(KIND_SCAN, X_W'($urandom), Y_W'($urandom), MODE_W'($urandom),
                          1'($urandom), PHASE_W'($urandom));
    random_items(40);
    drain();

    set_geometry(3'd3, 3'd1);
    random_items(40);
    drain();
    set_geometry(3'd1, 3'd2);
    random_items(30);
    drain();

    idling = 1'b0;
    set_geometry(3'd4, 3'd1);
    random_items(30);
    drain();

    if (sb.beats_due.size() != 0) begin
      $error("%0d scan beats never arrived", sb.beats_due.size());
      sb.errors++;
    end
    $display("run: %0d items (%0d pixel writes, %0d scans, %0d clears) over %0d geometries",
             n_items, n_writes, n_scans, n_clears, n_geometries);
    $display("run: %0d scan beats compared, %0d mismatches", sb.beats_checked, sb.errors);
    if (sb.errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/lmfs_pkg.sv
sv/lmfs_ram.sv
sv/led_matrix_frame_store_scanner.sv
sv/lmfs_checker.sv
tb/sv/tb_led_matrix_frame_store_scanner.sv
